@@ rtl/fpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants for the fixed-point atan2 pipeline.
// ----------------------------------------------------------------------------
package fpa_pkg;

  // Default width of the signed coordinate inputs.
  localparam int COORD_WIDTH_DEF = 22;

  // The ratio r has magnitude 0..256, so the quotient needs nine bits.
  localparam int QUO_WIDTH   = 9;
  localparam int DIV_STEPS   = 9;
  localparam int STAGE_STEPS = 3;
  localparam int DIV_STAGES  = DIV_STEPS / STAGE_STEPS;

  // Raw angle a lies in 0..804.
  localparam int A_WIDTH     = 10;
  localparam int A_MAX       = 804;
  localparam int ANGLE_WIDTH = 8;

  localparam int K1 = 201;
  localparam int K2 = 603;

  // Final scale is the exact ratio SCALE_NUM / SCALE_DEN, truncated.
  localparam longint SCALE_NUM = 64'd10000000;
  localparam longint SCALE_DEN = 64'd62831854;
  localparam int     PROD_WIDTH = 34;

  // Reciprocal estimate: floor(2^16 * SCALE_NUM / SCALE_DEN). It never
  // overshoots and falls short by at most one.
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP       = 10430;
  localparam int EST_WIDTH   = 24;
  localparam int Q_WIDTH     = 7;

  typedef struct packed {
    logic zero;    // both coordinates are zero
    logic neg_y;   // delta_y is negative
    logic neg_r;   // the ratio r is negative
    logic dx_neg;  // delta_x is negative, use the far half-plane offset
  } ctrl_t;

endpackage

@@ rtl/fpa_prep.sv @@
// ----------------------------------------------------------------------------
// fpa_prep
// Input stage: folds the coordinates into a divisor and a dividend magnitude.
// ----------------------------------------------------------------------------
module fpa_prep #(
  parameter int COORD_WIDTH = fpa_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic signed [COORD_WIDTH-1:0] delta_y_i,
  input  logic signed [COORD_WIDTH-1:0] delta_x_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [COORD_WIDTH+1:0]        rem_o,
  output logic [COORD_WIDTH:0]          den_o,
  output fpa_pkg::ctrl_t                ctrl_o
);

  localparam int EW = COORD_WIDTH + 2;

  logic signed [EW-1:0] dy_x, dx_x, ay, num, den, num_mag;
  logic [EW-1:0]        rem_d, rem_q;
  logic [COORD_WIDTH:0] den_d, den_q;
  fpa_pkg::ctrl_t       ctrl_d, ctrl_q;
  logic                 v_q;
  logic                 load;

  always_comb begin
    dy_x = EW'(delta_y_i);
    dx_x = EW'(delta_x_i);
    ay   = dy_x[EW-1] ? -dy_x : dy_x;
    if (!dx_x[EW-1]) begin
      num = dx_x - ay;
      den = dx_x + ay;
    end else begin
      num = dx_x + ay;
      den = ay - dx_x;
    end
    num_mag = num[EW-1] ? -num : num;
    rem_d   = num_mag;
    den_d   = den[COORD_WIDTH:0];
    ctrl_d.zero   = (delta_y_i == '0) && (delta_x_i == '0);
    ctrl_d.neg_y  = dy_x[EW-1];
    ctrl_d.neg_r  = num[EW-1];
    ctrl_d.dx_neg = dx_x[EW-1];
  end

  assign stall_o = v_q & stall_i;
  assign load    = valid_i & ~stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (!stall_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rem_q  <= rem_d;
      den_q  <= den_d;
      ctrl_q <= ctrl_d;
    end
  end

  assign valid_o = v_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign ctrl_o  = ctrl_q;

endmodule

@@ rtl/fpa_div_stage.sv @@
// ----------------------------------------------------------------------------
// fpa_div_stage
// One pipeline stage of the restoring divider, several quotient bits deep.
// ----------------------------------------------------------------------------
module fpa_div_stage #(
  parameter int COORD_WIDTH = fpa_pkg::COORD_WIDTH_DEF,
  parameter int STEPS       = fpa_pkg::STAGE_STEPS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic [COORD_WIDTH+1:0]        rem_i,
  input  logic [COORD_WIDTH:0]          den_i,
  input  logic [fpa_pkg::QUO_WIDTH-1:0] quo_i,
  input  fpa_pkg::ctrl_t                ctrl_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [COORD_WIDTH+1:0]        rem_o,
  output logic [COORD_WIDTH:0]          den_o,
  output logic [fpa_pkg::QUO_WIDTH-1:0] quo_o,
  output fpa_pkg::ctrl_t                ctrl_o
);

  localparam int RW = COORD_WIDTH + 2;
  localparam int QW = fpa_pkg::QUO_WIDTH;

  logic [RW-1:0]          rem_d, rem_q;
  logic [COORD_WIDTH:0]   den_q;
  logic [QW-1:0]          quo_d, quo_q;
  fpa_pkg::ctrl_t         ctrl_q;
  logic                   v_q;
  logic                   load;

  // Each step compares, subtracts when it fits and doubles the remainder.
  // The remainder stays below twice the divisor, so the doubling never
  // overflows RW bits.
  always_comb begin
    logic bit_q;
    rem_d = rem_i;
    quo_d = quo_i;
    for (int s = 0; s < STEPS; s++) begin
      bit_q = (rem_d >= RW'(den_i));
      if (bit_q) begin
        rem_d = rem_d - RW'(den_i);
      end
      rem_d = {rem_d[RW-2:0], 1'b0};
      quo_d = {quo_d[QW-2:0], bit_q};
    end
  end

  assign stall_o = v_q & stall_i;
  assign load    = valid_i & ~stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (!stall_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rem_q  <= rem_d;
      den_q  <= den_i;
      quo_q  <= quo_d;
      ctrl_q <= ctrl_i;
    end
  end

  assign valid_o = v_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign quo_o   = quo_q;
  assign ctrl_o  = ctrl_q;

  // The partial remainder must stay below twice the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q && !ctrl_q.zero) |-> (rem_q < {den_q, 1'b0}))
    else $error("divider remainder out of range");

endmodule

@@ rtl/fpa_scale.sv @@
// ----------------------------------------------------------------------------
// fpa_scale
// Back end: turns the ratio into the raw angle and scales it to 128 units
// per half turn over three register stages.
// ----------------------------------------------------------------------------
module fpa_scale (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  stall_o,
  input  logic [fpa_pkg::QUO_WIDTH-1:0]         quo_i,
  input  fpa_pkg::ctrl_t                        ctrl_i,
  output logic                                  valid_o,
  input  logic                                  stall_i,
  output logic signed [fpa_pkg::ANGLE_WIDTH-1:0] angle_o
);

  localparam int QW = fpa_pkg::QUO_WIDTH;
  localparam int AW = fpa_pkg::A_WIDTH;
  localparam int PW = fpa_pkg::PROD_WIDTH;
  localparam int EW = fpa_pkg::EST_WIDTH;
  localparam int OW = fpa_pkg::ANGLE_WIDTH;
  localparam int TW = fpa_pkg::Q_WIDTH;
  localparam int MW = 2 * 8;

  // Stage A: raw angle.
  logic [MW-1:0] m_prod;
  logic [7:0]    m_val;
  logic [AW-1:0] base, a_d, a_q;
  logic          va_q, neg_y_a_q, zero_a_q, stall_a;

  // Stage B: reciprocal estimate and exact numerator.
  logic [EW-1:0] est;
  logic [TW-1:0] q0_d, q0_q;
  logic [PW-1:0] lhs_d, lhs_q;
  logic          vb_q, neg_y_b_q, zero_b_q, stall_b;

  // Stage C: one-step correction and sign.
  logic [OW-1:0]        q1;
  logic [PW-1:0]        thr;
  logic [OW-1:0]        qf;
  logic signed [OW-1:0] angle_d, angle_q;
  logic                 vc_q, stall_c;

  assign stall_c = vc_q & stall_i;
  assign stall_b = vb_q & stall_c;
  assign stall_a = va_q & stall_b;
  assign stall_o = stall_a;

  // (K1 * r) / 256 truncates toward zero, so it is taken on the magnitude.
  always_comb begin
    m_prod = MW'(quo_i) * MW'(fpa_pkg::K1);
    m_val  = m_prod[MW-1:8];
    base   = ctrl_i.dx_neg ? AW'(fpa_pkg::K2) : AW'(fpa_pkg::K1);
    a_d    = ctrl_i.neg_r ? base + AW'(m_val) : base - AW'(m_val);
  end

  always_comb begin
    est   = EW'(a_q) * EW'(fpa_pkg::RECIP);
    q0_d  = est[fpa_pkg::RECIP_SHIFT +: TW];
    lhs_d = PW'(a_q) * PW'(fpa_pkg::SCALE_NUM);
  end

  // The estimate is exact or one short; a single compare settles it.
  always_comb begin
    q1  = OW'(q0_q) + OW'(1);
    thr = PW'(q1) * PW'(fpa_pkg::SCALE_DEN);
    qf  = (lhs_q >= thr) ? q1 : OW'(q0_q);
    if (zero_b_q) begin
      angle_d = '0;
    end else if (neg_y_b_q) begin
      angle_d = -$signed(qf);
    end else begin
      angle_d = $signed(qf);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (!stall_a) begin
        va_q <= valid_i;
      end
      if (!stall_b) begin
        vb_q <= va_q;
      end
      if (!stall_c) begin
        vc_q <= vb_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_a) begin
      a_q       <= a_d;
      neg_y_a_q <= ctrl_i.neg_y;
      zero_a_q  <= ctrl_i.zero;
    end
    if (va_q && !stall_b) begin
      q0_q      <= q0_d;
      lhs_q     <= lhs_d;
      neg_y_b_q <= neg_y_a_q;
      zero_b_q  <= zero_a_q;
    end
    if (vb_q && !stall_c) begin
      angle_q <= angle_d;
    end
  end

  assign valid_o = vc_q;
  assign angle_o = angle_q;

  // The ratio magnitude can never exceed one (256 with 8 fractional bits).
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !ctrl_i.zero) |-> (quo_i <= QW'(256)))
    else $error("ratio magnitude above one");

  // The raw angle stays within its range for every nonzero input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (va_q && !zero_a_q) |-> (a_q <= AW'(fpa_pkg::A_MAX)))
    else $error("raw angle out of range");

endmodule

@@ rtl/fixed_point_atan2.sv @@
// ----------------------------------------------------------------------------
// fixed_point_atan2
// Direction angle of a signed coordinate difference, 128 units per half turn.
// ----------------------------------------------------------------------------
// The block takes one (delta_y, delta_x) beat per clock while not stalled and
// returns one angle beat for each, in order. Each beat passes through seven
// register stages before its angle is presented: the nine-bit restoring
// divider retires three quotient bits in each of three stages, plus one
// input stage and three stages that form and scale the raw angle. Stalls
// travel back stage by stage, so empty stages still fill while the output
// waits.
// ----------------------------------------------------------------------------
module fixed_point_atan2 #(
  parameter int COORD_WIDTH = fpa_pkg::COORD_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [COORD_WIDTH-1:0]          delta_y_i,
  input  logic signed [COORD_WIDTH-1:0]          delta_x_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [fpa_pkg::ANGLE_WIDTH-1:0] angle_o
);

  localparam int NS = fpa_pkg::DIV_STAGES;
  localparam int QW = fpa_pkg::QUO_WIDTH;

  logic                   div_v     [NS+1];
  logic                   div_stall [NS+1];
  logic [COORD_WIDTH+1:0] div_rem   [NS+1];
  logic [COORD_WIDTH:0]   div_den   [NS+1];
  logic [QW-1:0]          div_quo   [NS+1];
  fpa_pkg::ctrl_t         div_ctrl  [NS+1];

  fpa_prep #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .stall_o  (in_stall_o),
    .delta_y_i(delta_y_i),
    .delta_x_i(delta_x_i),
    .valid_o  (div_v[0]),
    .stall_i  (div_stall[0]),
    .rem_o    (div_rem[0]),
    .den_o    (div_den[0]),
    .ctrl_o   (div_ctrl[0])
  );

  assign div_quo[0] = '0;

  for (genvar k = 0; k < NS; k++) begin : g_div
    fpa_div_stage #(
      .COORD_WIDTH(COORD_WIDTH),
      .STEPS      (fpa_pkg::STAGE_STEPS)
    ) u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(div_v[k]),
      .stall_o(div_stall[k]),
      .rem_i  (div_rem[k]),
      .den_i  (div_den[k]),
      .quo_i  (div_quo[k]),
      .ctrl_i (div_ctrl[k]),
      .valid_o(div_v[k+1]),
      .stall_i(div_stall[k+1]),
      .rem_o  (div_rem[k+1]),
      .den_o  (div_den[k+1]),
      .quo_o  (div_quo[k+1]),
      .ctrl_o (div_ctrl[k+1])
    );
  end

  fpa_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(div_v[NS]),
    .stall_o(div_stall[NS]),
    .quo_i  (div_quo[NS]),
    .ctrl_i (div_ctrl[NS]),
    .valid_o(out_valid_o),
    .stall_i(out_stall_i),
    .angle_o(angle_o)
  );

  // The most negative code is never produced: angles stay within -127..127.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(angle_o[fpa_pkg::ANGLE_WIDTH-1] &&
                      (angle_o[fpa_pkg::ANGLE_WIDTH-2:0] == '0)))
    else $error("angle outside -127..127");

endmodule
